// File: src/assert_macros.svh
// Assertion helpers used by the top-level RTL; empty under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Expression must never be true while out of reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion violated");
// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion violated");
`else
`define ASSERT_NEVER(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/qph_pkg.sv
package qph_pkg;

  localparam int KeyW      = 31;
  localparam int ValW      = 64;
  localparam int StatW     = 3;
  localparam int QDepth    = 2;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

  typedef enum logic [StatW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    action_t               action;
    logic [KeyW-1:0]       key;
    logic [ValW-1:0]       value;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic [KeyW-1:0]       key;
    logic [ValW-1:0]       value;
  } slot_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE
  } back_state_t;

endpackage

// File: src/qph_if.sv
// Request channel
interface qph_in_if import qph_pkg::*; ();
  logic                valid;
  logic                ready;
  action_t             action;
  logic [KeyW-1:0]     key;
  logic [ValW-1:0]     value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

// Result channel
interface qph_out_if import qph_pkg::*; #(parameter int IdxW = 4) ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [IdxW-1:0]     slot_index;
  logic [ValW-1:0]     found_value;

  modport source (output valid, status, slot_index, found_value, input ready);
  modport sink   (input valid, status, slot_index, found_value, output ready);
endinterface

// File: src/qph_ram.sv
module qph_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/qph_fifo.sv
module qph_fifo import qph_pkg::*; #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] pop_data,
  output logic             empty
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  logic [Width-1:0] entry [QDepth];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [CntW-1:0]  count;

  assign full     = (count == CntW'(QDepth));
  assign empty    = (count == '0);
  assign pop_data = entry[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrW'(QDepth - 1)) ? '0 : wptr + PtrW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PtrW'(QDepth - 1)) ? '0 : rptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

endmodule

// File: src/qph_front.sv
module qph_front import qph_pkg::*; #(
  parameter int SLOTS = 15,
  parameter int IdxW  = $clog2(SLOTS)
) (
  input  logic            clk,
  input  logic            rst,
  qph_in_if.sink          in_ch,
  input  logic            clearing,
  output logic            push,
  output item_t           push_item,
  output logic [IdxW-1:0] push_home,
  input  logic            full
);

  // Reciprocal of SLOTS scaled by 2^Sh and rounded up; exact for every key
  localparam int RecW  = KeyW + 1;
  localparam int Sh    = KeyW + IdxW;
  localparam int ProdW = KeyW + RecW;
  localparam int QuoW  = ProdW - Sh;
  localparam logic [63:0]      RecipWide = ((64'd1 << Sh) + 64'(SLOTS - 1)) / 64'(SLOTS);
  localparam logic [RecW-1:0]  Recip     = RecipWide[RecW-1:0];
  localparam logic [KeyW-1:0]  SlotsK    = KeyW'(SLOTS);

  front_state_t     state;
  front_state_t     state_next;
  item_t            item;
  logic [ProdW-1:0] prod;
  logic [QuoW-1:0]  quot;
  logic [KeyW-1:0]  quot_slots;
  logic [KeyW-1:0]  rem_full;
  logic             take;

  assign take      = in_ch.valid && in_ch.ready;
  assign push_item = item;
  assign push_home = rem_full[IdxW-1:0];

  // Quotient by reciprocal multiply, remainder by multiply back and subtract
  assign prod       = {{RecW{1'b0}}, item.key} * {{KeyW{1'b0}}, Recip};
  assign quot_slots = KeyW'(quot) * SlotsK;
  assign rem_full   = item.key - quot_slots;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch item, then the quotient of its key
  always_ff @(posedge clk) begin
    if (take) begin
      item <= '{action: in_ch.action, key: in_ch.key, value: in_ch.value};
    end
    if (state == F_DIV) begin
      quot <= prod[ProdW-1:Sh];
    end
  end

  // Sequence accept, reduce and hand over
  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    push        = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ch.ready = !clearing;
        if (take) begin
          state_next = F_DIV;
        end
      end
      F_DIV: begin
        state_next = F_PUSH;
      end
      F_PUSH: begin
        push = !full;
        if (!full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

endmodule

// File: src/qph_back.sv
module qph_back import qph_pkg::*; #(
  parameter int SLOTS = 15,
  parameter int IdxW  = $clog2(SLOTS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  output logic            pop,
  input  item_t           pop_item,
  input  logic [IdxW-1:0] pop_home,
  output logic            clearing,
  qph_out_if.source       out_ch
);

  localparam logic [IdxW:0]   SlotsW = (IdxW + 1)'(SLOTS);
  localparam logic [IdxW-1:0] Last   = IdxW'(SLOTS - 1);

  back_state_t      state;
  back_state_t      state_next;
  logic [IdxW-1:0]  clr_cnt;
  logic [IdxW-1:0]  pos;
  logic [IdxW-1:0]  inc;
  logic [IdxW-1:0]  cnt;
  item_t            cur;
  logic [IdxW:0]    pos_sum;
  logic [IdxW:0]    inc_sum;
  logic [IdxW-1:0]  pos_nx;
  logic [IdxW-1:0]  inc_nx;

  logic             we;
  logic [IdxW-1:0]  waddr;
  slot_t            wdata;
  logic [IdxW-1:0]  raddr;
  logic [$bits(slot_t)-1:0] rdata;
  slot_t            rd;
  logic             hit;

  logic             finish;
  logic             load_out;
  logic             advance;
  logic             out_free;
  status_t          fin_status;
  logic [IdxW-1:0]  fin_idx;
  logic [ValW-1:0]  fin_val;

  logic             out_valid;
  status_t          out_status;
  logic [IdxW-1:0]  out_idx;
  logic [ValW-1:0]  out_val;

  qph_ram #(
    .Width ($bits(slot_t)),
    .Depth (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd       = slot_t'(rdata);
  assign hit      = rd.valid && (rd.key == cur.key);
  assign clearing = (state == B_CLEAR);
  assign out_free = !out_valid || out_ch.ready;

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.slot_index  = out_idx;
  assign out_ch.found_value = out_val;

  // Next probe: pos += 2i+1 and inc += 2, both mod SLOTS
  always_comb begin
    pos_sum = {1'b0, pos} + {1'b0, inc};
    if (pos_sum >= SlotsW) begin
      pos_sum = pos_sum - SlotsW;
    end
    inc_sum = {1'b0, inc} + (IdxW + 1)'(2);
    if (inc_sum >= SlotsW) begin
      inc_sum = inc_sum - SlotsW;
    end
    pos_nx = pos_sum[IdxW-1:0];
    inc_nx = inc_sum[IdxW-1:0];
  end

  // Classify the slot just read
  always_comb begin
    finish     = 1'b0;
    fin_status = ST_FULL;
    fin_idx    = '0;
    fin_val    = '0;
    if (cur.action == ACT_INSERT) begin
      if (!rd.valid) begin
        finish     = 1'b1;
        fin_status = ST_INSERTED;
        fin_idx    = pos;
      end else if (hit) begin
        finish     = 1'b1;
        fin_status = ST_DUPLICATE;
      end else if (cnt == Last) begin
        finish     = 1'b1;
        fin_status = ST_FULL;
      end
    end else begin
      if (!rd.valid) begin
        finish     = 1'b1;
        fin_status = ST_NOT_FOUND;
      end else if (hit) begin
        finish     = 1'b1;
        fin_status = ST_FOUND;
        fin_idx    = pos;
        fin_val    = rd.value;
      end else if (cnt == Last) begin
        finish     = 1'b1;
        fin_status = ST_NOT_FOUND;
      end
    end
  end

  // Sequence clear, fetch and probe
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    we         = 1'b0;
    waddr      = pos;
    wdata      = '{valid: 1'b1, key: cur.key, value: cur.value};
    raddr      = pos;
    load_out   = 1'b0;
    advance    = 1'b0;
    unique case (state)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
        if (clr_cnt == Last) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        raddr = pop_home;
        if (!empty) begin
          pop        = 1'b1;
          state_next = B_PROBE;
        end
      end
      B_PROBE: begin
        if (finish) begin
          if (out_free) begin
            load_out   = 1'b1;
            we         = (fin_status == ST_INSERTED);
            state_next = B_IDLE;
          end
        end else begin
          advance = 1'b1;
          raddr   = pos_nx;
        end
      end
      default: state_next = B_CLEAR;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_cnt <= clr_cnt + IdxW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the next item, advance the probe, capture the result
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_item;
      pos <= pop_home;
      inc <= IdxW'(1);
      cnt <= '0;
    end else if (advance) begin
      pos <= pos_nx;
      inc <= inc_nx;
      cnt <= cnt + IdxW'(1);
    end
    if (load_out) begin
      out_status <= fin_status;
      out_idx    <= fin_idx;
      out_val    <= fin_val;
    end
  end

endmodule

// File: src/quadratic_probe_hash_table_top.sv
// From the accepting edge to a valid result: key quotient, queue push, home slot read,
// then 1 to SLOTS probes. The front end takes a new item while the back end probes
// the last one, and stalls once the queue is full, as when a result waits; the slot
// memory's single read port takes one probe a cycle.
// Reset: synchronous; a clearing pass then zeroes every slot, and no item is accepted
// until it ends.
`include "assert_macros.svh"

module quadratic_probe_hash_table_top import qph_pkg::*; #(
  parameter int SLOTS = 15
) (
  input  logic      clk,
  input  logic      rst,
  qph_in_if.sink    in_ch,
  qph_out_if.source out_ch
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int QW   = $bits(item_t) + IdxW;

  logic            clearing;
  logic            push;
  item_t           push_item;
  logic [IdxW-1:0] push_home;
  logic            full;
  logic            pop;
  logic [QW-1:0]   pop_data;
  item_t           pop_item;
  logic [IdxW-1:0] pop_home;
  logic            empty;

  qph_front #(
    .SLOTS (SLOTS),
    .IdxW  (IdxW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .clearing  (clearing),
    .push      (push),
    .push_item (push_item),
    .push_home (push_home),
    .full      (full)
  );

  qph_fifo #(
    .Width (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_item, push_home}),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Split the queued word back into item and home slot
  assign pop_item = item_t'(pop_data[QW-1:IdxW]);
  assign pop_home = pop_data[IdxW-1:0];

  qph_back #(
    .SLOTS (SLOTS),
    .IdxW  (IdxW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop      (pop),
    .pop_item (pop_item),
    .pop_home (pop_home),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

  `ASSERT_IMPLY(a_no_take_in_clear, clk, rst, in_ch.ready, !clearing)
  `ASSERT_NEVER(a_queue_overflow, clk, rst, push && full)
  `ASSERT_NEVER(a_queue_underflow, clk, rst, pop && empty)

endmodule

// File: bench/quadratic_probe_hash_table_top_tb.sv
`timescale 1ns / 1ps

module quadratic_probe_hash_table_top_tb;
  import qph_pkg::*;

  localparam int N_SLOTS    = 15;
  localparam int IDX_W      = $clog2(N_SLOTS);
  localparam int POOL_SIZE  = 24;
  localparam int PHASE_REQS = 470;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 40;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] slot;
    logic [ValW-1:0]  value;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;

  qph_in_if                   in_ch ();
  qph_out_if #(.IdxW(IDX_W))  out_ch ();

  quadratic_probe_hash_table_top #(.SLOTS(N_SLOTS)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the slot table
  bit              tbl_valid [N_SLOTS];
  logic [KeyW-1:0] tbl_key   [N_SLOTS];
  logic [ValW-1:0] tbl_value [N_SLOTS];

  item_t    pending_requests [$];
  outcome_t expected_results [$];
  item_t    next_req;
  outcome_t oldest;

  int queued_reqs    = 0;
  int accepted_reqs  = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int status_seen [5];

  // Probe the shadow table the way the block does and update it on insert
  function automatic outcome_t apply_request(action_t act, logic [KeyW-1:0] k,
                                             logic [ValW-1:0] v);
    int unsigned home;
    int unsigned pos;
    int unsigned i;
    outcome_t    res;
    res.status = (act == ACT_SEARCH) ? ST_NOT_FOUND : ST_FULL;
    res.slot   = '0;
    res.value  = '0;
    home = k % N_SLOTS;
    for (i = 0; i < N_SLOTS; i++) begin
      pos = (home + i * i) % N_SLOTS;
      if (act == ACT_INSERT) begin
        if (!tbl_valid[pos]) begin
          tbl_valid[pos] = 1'b1;
          tbl_key[pos]   = k;
          tbl_value[pos] = v;
          res.status     = ST_INSERTED;
          res.slot       = IDX_W'(pos);
          break;
        end
        if (tbl_key[pos] == k) begin
          res.status = ST_DUPLICATE;
          break;
        end
      end else begin
        if (!tbl_valid[pos]) break;
        if (tbl_key[pos] == k) begin
          res.status = ST_FOUND;
          res.slot   = IDX_W'(pos);
          res.value  = tbl_value[pos];
          break;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 20) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  task automatic queue_request(input action_t act, input logic [KeyW-1:0] k,
                               input logic [ValW-1:0] v);
    item_t req;
    req.action = act;
    req.key    = k;
    req.value  = v;
    pending_requests.push_back(req);
    queued_reqs++;
  endtask

  // Present the next pending item once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_requests.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.action <= next_req.action;
        in_ch.key    <= next_req.key;
        in_ch.value  <= next_req.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict on accepted items, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_request(in_ch.action, in_ch.key, in_ch.value));
        accepted_reqs++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (int'(out_ch.status) < 5) status_seen[int'(out_ch.status)]++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          oldest = expected_results.pop_front();
          if (out_ch.status !== oldest.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d", results_seen,
                                      out_ch.status, oldest.status));
          if (out_ch.slot_index !== oldest.slot)
            report_mismatch($sformatf("result %0d slot %0d, want %0d", results_seen,
                                      out_ch.slot_index, oldest.slot));
          if (out_ch.found_value !== oldest.value)
            report_mismatch($sformatf("result %0d value %h, want %h", results_seen,
                                      out_ch.found_value, oldest.value));
        end
        results_seen++;
      end
      // Count stalled cycles only while work is outstanding
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else if (accepted_reqs != queued_reqs || expected_results.size() != 0)
        idle_cycles++;
    end
  end

  // Abort when nothing moves for too long
  initial begin
    do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
    $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
    $display("quadratic_probe_hash_table_top: mismatch");
    $finish;
  end

  initial begin
    logic [KeyW-1:0] key_pool [POOL_SIZE];
    logic [KeyW-1:0] k;
    logic [ValW-1:0] v;
    action_t         act;
    int              phase;
    int              n;

    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_INSERT;
    in_ch.key    = '0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    for (n = 0; n < 5; n++) status_seen[n] = 0;

    // Keys that share four home slots so probing chains form
    for (n = 0; n < POOL_SIZE; n++)
      key_pool[n] = KeyW'((($urandom & 32'h7FFF_FFF0) / N_SLOTS) * N_SLOTS + (n % 4));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Search on an empty table stops at the free home slot
    queue_request(ACT_SEARCH, '0, '0);
    // Field extremes
    queue_request(ACT_INSERT, '0, '0);
    queue_request(ACT_INSERT, {KeyW{1'b1}}, {ValW{1'b1}});
    queue_request(ACT_SEARCH, {KeyW{1'b1}}, '0);
    queue_request(ACT_SEARCH, '0, {ValW{1'b1}});
    // Duplicate insert leaves the table alone
    queue_request(ACT_INSERT, '0, 64'd5);
    // Fill every slot reachable from home zero
    queue_request(ACT_INSERT, 31'd15, 64'h0123_4567_89AB_CDEF);
    queue_request(ACT_INSERT, 31'd30, 64'hFEDC_BA98_7654_3210);
    queue_request(ACT_INSERT, 31'd45, 64'h8000_0000_0000_0001);
    queue_request(ACT_INSERT, 31'd60, 64'h7FFF_FFFF_FFFF_FFFE);
    queue_request(ACT_INSERT, 31'd75, 64'h0000_0001_0000_0000);
    // Table full although free slots remain elsewhere
    queue_request(ACT_INSERT, 31'd90, 64'h1111_2222_3333_4444);
    // Search exhausts the probe sequence, then finds the last key deep in the chain
    queue_request(ACT_SEARCH, 31'd105, '0);
    queue_request(ACT_SEARCH, 31'd75, '0);
    // Collision, then a free slot on the second probe, then inserts at free home slots
    queue_request(ACT_SEARCH, 31'd22, '0);
    queue_request(ACT_INSERT, 31'd22, 64'hDEAD_BEEF_CAFE_F00D);
    queue_request(ACT_SEARCH, 31'd22, 64'hFFFF_0000_FFFF_0000);
    queue_request(ACT_INSERT, 31'd14, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_request(ACT_INSERT, 31'd5, 64'h5555_5555_5555_5555);
    wait (accepted_reqs == queued_reqs);

    // Random traffic under four idling patterns
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (n = 0; n < PHASE_REQS; n++) begin
        v = {$urandom, $urandom};
        if ($urandom_range(9) == 0) begin
          act = $urandom_range(1) ? ACT_SEARCH : ACT_INSERT;
          k   = KeyW'($urandom);
        end else begin
          act = ($urandom_range(9) < 4) ? ACT_INSERT : ACT_SEARCH;
          k   = key_pool[$urandom_range(POOL_SIZE - 1)];
        end
        queue_request(act, k, v);
      end
      wait (accepted_reqs == queued_reqs);
    end

    // Drain remaining results, then allow stragglers to show up
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Ran %0d operations, checked %0d results under four handshake patterns.",
             accepted_reqs, results_seen);
    $display("Outcomes: inserted %0d, duplicate %0d, full %0d, found %0d, not found %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("quadratic_probe_hash_table_top: match");
    end else begin
      $display("quadratic_probe_hash_table_top: mismatch");
    end
    $finish;
  end

endmodule

// File: quadratic_probe_hash_table_top.f
+incdir+src
src/qph_pkg.sv
src/qph_if.sv
src/qph_ram.sv
src/qph_fifo.sv
src/qph_front.sv
src/qph_back.sv
src/quadratic_probe_hash_table_top.sv
bench/quadratic_probe_hash_table_top_tb.sv
